// ===== rtl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Types and constants for the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] value;
  } hsv_pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_pixel_t;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_e;

  localparam logic [8:0]  HUE_FULL    = 9'd360;
  localparam logic [6:0]  PCT_MAX     = 7'd100;
  localparam logic [6:0]  SECTOR_DEG  = 7'd60;
  // 60 * 100: full scale of one term numerator before the value multiply
  localparam logic [12:0] TERM_FULL   = 13'd6000;
  // ceil(2^28 / 625); exact floor division for dividends below 2^18
  localparam logic [18:0] RECIP_625   = 19'd429497;
  localparam int          RECIP_SHIFT = 28;

endpackage

`default_nettype wire

// ===== rtl/hsv_to_rgb_converter_unit.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// HSV (degrees, percent, percent) to 8-bit RGB, exact integer arithmetic.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle; busy_o is never raised, the six-stage
// pipeline always advances.
// Reset clears the stage valid bits only; the datapath registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_unit
  import hsv2rgb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire hsv_pixel_t pixel_i,
  output logic            busy_o,
  output logic            result_valid_o,
  output rgb_pixel_t      pixel_o
);

  localparam int NumStages = 6;

  logic [NumStages-1:0] valid_q;
  logic                 accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NumStages-2:0], accept};
    end
  end

  assign result_valid_o = valid_q[NumStages-1];

  // Stage 1: hue wrap, percent clamps
  logic [8:0] s1_hue_d, s1_hue_q;
  logic [6:0] s1_sat_d, s1_sat_q;
  logic [6:0] s1_val_d, s1_val_q;

  always_comb begin
    s1_hue_d = (pixel_i.hue >= HUE_FULL) ? (pixel_i.hue - HUE_FULL) : pixel_i.hue;
    s1_sat_d = (pixel_i.saturation > PCT_MAX) ? PCT_MAX : pixel_i.saturation;
    s1_val_d = (pixel_i.value > PCT_MAX) ? PCT_MAX : pixel_i.value;
  end

  always_ff @(posedge clk_i) begin
    s1_hue_q <= s1_hue_d;
    s1_sat_q <= s1_sat_d;
    s1_val_q <= s1_val_d;
  end

  // Stage 2: sector and remainder in degrees
  sector_e    s2_sec_d, s2_sec_q;
  logic [8:0] s2_base;
  logic [8:0] s2_rem_full;
  logic [5:0] s2_rem_q;
  logic [6:0] s2_sat_q;
  logic [6:0] s2_val_q;

  always_comb begin
    if (s1_hue_q >= 9'd300) begin
      s2_sec_d = SEC_MAGENTA_RED;
      s2_base  = 9'd300;
    end else if (s1_hue_q >= 9'd240) begin
      s2_sec_d = SEC_BLUE_MAGENTA;
      s2_base  = 9'd240;
    end else if (s1_hue_q >= 9'd180) begin
      s2_sec_d = SEC_CYAN_BLUE;
      s2_base  = 9'd180;
    end else if (s1_hue_q >= 9'd120) begin
      s2_sec_d = SEC_GREEN_CYAN;
      s2_base  = 9'd120;
    end else if (s1_hue_q >= {2'b00, SECTOR_DEG}) begin
      s2_sec_d = SEC_YELLOW_GREEN;
      s2_base  = {2'b00, SECTOR_DEG};
    end else begin
      s2_sec_d = SEC_RED_YELLOW;
      s2_base  = 9'd0;
    end
    s2_rem_full = s1_hue_q - s2_base;
  end

  always_ff @(posedge clk_i) begin
    s2_sec_q <= s2_sec_d;
    s2_rem_q <= s2_rem_full[5:0];
    s2_sat_q <= s1_sat_q;
    s2_val_q <= s1_val_q;
  end

  // Stage 3: saturation products
  sector_e     s3_sec_q;
  logic [6:0]  s3_val_q;
  logic [12:0] s3_fall_d, s3_fall_q;   // rem * s
  logic [12:0] s3_rise_d, s3_rise_q;   // (60 - rem) * s
  logic [12:0] s3_flat_d, s3_flat_q;   // (100 - s) * 60
  logic [6:0]  s3_rem_c;
  logic [6:0]  s3_sat_c;

  always_comb begin
    s3_rem_c  = SECTOR_DEG - {1'b0, s2_rem_q};
    s3_sat_c  = PCT_MAX - s2_sat_q;
    s3_fall_d = {7'd0, s2_rem_q} * {6'd0, s2_sat_q};
    s3_rise_d = {6'd0, s3_rem_c} * {6'd0, s2_sat_q};
    s3_flat_d = {6'd0, s3_sat_c} * {6'd0, SECTOR_DEG};
  end

  always_ff @(posedge clk_i) begin
    s3_sec_q  <= s2_sec_q;
    s3_val_q  <= s2_val_q;
    s3_fall_q <= s3_fall_d;
    s3_rise_q <= s3_rise_d;
    s3_flat_q <= s3_flat_d;
  end

  // Stage 4: numerators over 600000
  sector_e     s4_sec_q;
  logic [19:0] s4_nv_q, s4_np_q, s4_nq_q, s4_nt_q;
  logic [12:0] s4_xq, s4_xt;

  always_comb begin
    s4_xq = TERM_FULL - s3_fall_q;
    s4_xt = TERM_FULL - s3_rise_q;
  end

  always_ff @(posedge clk_i) begin
    s4_sec_q <= s3_sec_q;
    s4_nv_q  <= {13'd0, s3_val_q} * {7'd0, TERM_FULL};
    s4_np_q  <= {13'd0, s3_val_q} * {7'd0, s3_flat_q};
    s4_nq_q  <= {13'd0, s3_val_q} * {7'd0, s4_xq};
    s4_nt_q  <= {13'd0, s3_val_q} * {7'd0, s4_xt};
  end

  // Stage 5: sector select, times 17, drop the power of two of 40000
  logic [19:0] s5_r, s5_g, s5_b;
  logic [24:0] s5_r17, s5_g17, s5_b17;
  logic [17:0] s5_r_q, s5_g_q, s5_b_q;

  always_comb begin
    case (s4_sec_q)
      SEC_RED_YELLOW: begin
        s5_r = s4_nv_q; s5_g = s4_nt_q; s5_b = s4_np_q;
      end
      SEC_YELLOW_GREEN: begin
        s5_r = s4_nq_q; s5_g = s4_nv_q; s5_b = s4_np_q;
      end
      SEC_GREEN_CYAN: begin
        s5_r = s4_np_q; s5_g = s4_nv_q; s5_b = s4_nt_q;
      end
      SEC_CYAN_BLUE: begin
        s5_r = s4_np_q; s5_g = s4_nq_q; s5_b = s4_nv_q;
      end
      SEC_BLUE_MAGENTA: begin
        s5_r = s4_nt_q; s5_g = s4_np_q; s5_b = s4_nv_q;
      end
      default: begin
        s5_r = s4_nv_q; s5_g = s4_np_q; s5_b = s4_nq_q;
      end
    endcase
    // n * 255 / 600000 == n * 17 / (64 * 625)
    s5_r17 = {1'b0, s5_r, 4'b0000} + {5'b00000, s5_r};
    s5_g17 = {1'b0, s5_g, 4'b0000} + {5'b00000, s5_g};
    s5_b17 = {1'b0, s5_b, 4'b0000} + {5'b00000, s5_b};
  end

  always_ff @(posedge clk_i) begin
    s5_r_q <= s5_r17[23:6];
    s5_g_q <= s5_g17[23:6];
    s5_b_q <= s5_b17[23:6];
  end

  // Stage 6: divide by 625 through the reciprocal, result register
  logic [36:0] s6_r_prod, s6_g_prod, s6_b_prod;
  rgb_pixel_t  pixel_q;

  always_comb begin
    s6_r_prod = {1'b0, s5_r_q} * {18'd0, RECIP_625};
    s6_g_prod = {1'b0, s5_g_q} * {18'd0, RECIP_625};
    s6_b_prod = {1'b0, s5_b_q} * {18'd0, RECIP_625};
  end

  always_ff @(posedge clk_i) begin
    pixel_q.red   <= s6_r_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    pixel_q.green <= s6_g_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    pixel_q.blue  <= s6_b_prod[RECIP_SHIFT+7:RECIP_SHIFT];
  end

  assign pixel_o = pixel_q;

endmodule

`default_nettype wire

// ===== tb/hsv_to_rgb_checker.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_checker
// Watches the pixel command and result channels of the HSV to RGB converter,
// predicts each RGB pixel with exact integer arithmetic and compares the
// results in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hsv_to_rgb_checker
  import hsv2rgb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  hsv_pixel_t pixel_i,
  input  logic       result_valid_i,
  input  rgb_pixel_t result_i,
  output int         fail_count_o,
  output int         pending_o
);

  // every term is a numerator over 60 * 100 * 100
  localparam int unsigned TERM_DEN    = 600000;
  localparam int unsigned CHANNEL_MAX = 255;

  typedef struct {
    hsv_pixel_t src;
    rgb_pixel_t rgb;
  } rgb_expect_t;

  rgb_expect_t rgb_expected_q[$];
  int          mismatch_cnt = 0;
  int          pending_cnt  = 0;

  assign fail_count_o = mismatch_cnt;
  assign pending_o    = pending_cnt;

  function automatic logic [7:0] to_channel(int unsigned num);
    return 8'((num * CHANNEL_MAX) / TERM_DEN);
  endfunction

  function automatic rgb_pixel_t hsv_to_rgb_expected(hsv_pixel_t px);
    int unsigned h, s, v, rem, nv, np, nq, nt;
    sector_e     sec;
    rgb_pixel_t  rgb;
    h   = int'(px.hue) % int'(HUE_FULL);
    s   = (px.saturation > PCT_MAX) ? int'(PCT_MAX) : int'(px.saturation);
    v   = (px.value > PCT_MAX) ? int'(PCT_MAX) : int'(px.value);
    sec = sector_e'(3'(h / int'(SECTOR_DEG)));
    rem = h % int'(SECTOR_DEG);
    nv  = v * int'(TERM_FULL);
    np  = v * (int'(PCT_MAX) - s) * int'(SECTOR_DEG);
    nq  = v * (int'(TERM_FULL) - rem * s);
    nt  = v * (int'(TERM_FULL) - (int'(SECTOR_DEG) - rem) * s);
    case (sec)
      SEC_RED_YELLOW: begin
        rgb.red = to_channel(nv); rgb.green = to_channel(nt); rgb.blue = to_channel(np);
      end
      SEC_YELLOW_GREEN: begin
        rgb.red = to_channel(nq); rgb.green = to_channel(nv); rgb.blue = to_channel(np);
      end
      SEC_GREEN_CYAN: begin
        rgb.red = to_channel(np); rgb.green = to_channel(nv); rgb.blue = to_channel(nt);
      end
      SEC_CYAN_BLUE: begin
        rgb.red = to_channel(np); rgb.green = to_channel(nq); rgb.blue = to_channel(nv);
      end
      SEC_BLUE_MAGENTA: begin
        rgb.red = to_channel(nt); rgb.green = to_channel(np); rgb.blue = to_channel(nv);
      end
      default: begin
        rgb.red = to_channel(nv); rgb.green = to_channel(np); rgb.blue = to_channel(nq);
      end
    endcase
    return rgb;
  endfunction

  function automatic void check_channel(string name, hsv_pixel_t src,
                                        logic [7:0] exp_val, logic [7:0] act_val);
    if (act_val !== exp_val) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch for h=%0d s=%0d v=%0d: expected %0d, actual %0d",
               $time, name, src.hue, src.saturation, src.value, exp_val, act_val);
    end
  endfunction

  always @(posedge clk_i) begin
    rgb_expect_t exp_pix;
    if (rst_ni) begin
      // results first: the converter registers its result, so a result never belongs to
      // the transaction accepted at the same edge
      if (result_valid_i) begin
        if (rgb_expected_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result: expected none, actual r=%0d g=%0d b=%0d",
                   $time, result_i.red, result_i.green, result_i.blue);
        end else begin
          exp_pix = rgb_expected_q.pop_front();
          check_channel("red",   exp_pix.src, exp_pix.rgb.red,   result_i.red);
          check_channel("green", exp_pix.src, exp_pix.rgb.green, result_i.green);
          check_channel("blue",  exp_pix.src, exp_pix.rgb.blue,  result_i.blue);
        end
      end
      if (start_i && !busy_i) begin
        exp_pix.src = pixel_i;
        exp_pix.rgb = hsv_to_rgb_expected(pixel_i);
        rgb_expected_q.push_back(exp_pix);
      end
      pending_cnt = rgb_expected_q.size();
    end
  end

endmodule

// ===== tb/tb_hsv_to_rgb_converter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_unit
// Drives directed and random HSV pixels into the converter with varying
// sender gaps; the checker predicts and compares every RGB result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter_unit;
  import hsv2rgb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int PHASE_PIXELS  = 320;

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  hsv_pixel_t pixel_i;
  logic       busy_o;
  logic       result_valid_o;
  rgb_pixel_t pixel_o;
  int         fail_count;
  int         pending_count;
  int         cycle_cnt = 0;

  hsv_to_rgb_converter_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .pixel_i        (pixel_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .pixel_o        (pixel_o)
  );

  hsv_to_rgb_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .pixel_i        (pixel_i),
    .result_valid_i (result_valid_o),
    .result_i       (pixel_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_count)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic hsv_pixel_t pixel_of(int unsigned h, int unsigned s, int unsigned v);
    hsv_pixel_t px;
    px.hue        = 9'(h);
    px.saturation = 7'(s);
    px.value      = 7'(v);
    return px;
  endfunction

  // mostly legal pixels; the rest spans the full field widths
  function automatic hsv_pixel_t random_pixel();
    if ($urandom_range(99) < 85)
      return pixel_of($urandom_range(360), $urandom_range(100), $urandom_range(100));
    return pixel_of($urandom_range(511), $urandom_range(127), $urandom_range(127));
  endfunction

  // entered and left at a falling edge; start stays high into the next call
  task automatic drive_pixel(input hsv_pixel_t px, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    pixel_i = px;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start_i = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    pixel_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // sector boundaries, wrap of hue, clamps and zero terms
    drive_pixel(pixel_of(0, 100, 100), 0);
    drive_pixel(pixel_of(59, 100, 100), 0);
    drive_pixel(pixel_of(60, 100, 100), 0);
    drive_pixel(pixel_of(119, 100, 100), 0);
    drive_pixel(pixel_of(120, 100, 100), 0);
    drive_pixel(pixel_of(179, 100, 100), 0);
    drive_pixel(pixel_of(180, 100, 100), 0);
    drive_pixel(pixel_of(239, 100, 100), 0);
    drive_pixel(pixel_of(240, 100, 100), 0);
    drive_pixel(pixel_of(299, 100, 100), 0);
    drive_pixel(pixel_of(300, 100, 100), 0);
    drive_pixel(pixel_of(359, 100, 100), 0);
    drive_pixel(pixel_of(360, 100, 100), 0);
    drive_pixel(pixel_of(361, 100, 100), 0);
    drive_pixel(pixel_of(511, 127, 127), 0);
    drive_pixel(pixel_of(0, 0, 0), 0);
    drive_pixel(pixel_of(180, 0, 100), 0);
    drive_pixel(pixel_of(30, 50, 100), 0);
    drive_pixel(pixel_of(90, 101, 50), 0);
    drive_pixel(pixel_of(210, 100, 101), 0);
    drive_pixel(pixel_of(330, 127, 0), 0);
    drive_pixel(pixel_of(45, 1, 1), 0);
    drive_pixel(pixel_of(270, 99, 99), 0);
    drive_pixel(pixel_of(150, 64, 64), 0);
    drain_results();

    for (int i = 0; i < PHASE_PIXELS; i++) drive_pixel(random_pixel(), 7);
    for (int i = 0; i < PHASE_PIXELS; i++) drive_pixel(random_pixel(), 73);
    for (int i = 0; i < PHASE_PIXELS - 10; i++) begin
      // hold off once mid-stream until the pipeline is empty
      if (i == PHASE_PIXELS / 2) drain_results();
      drive_pixel(random_pixel(), 0);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hsv2rgb_pkg.sv
rtl/hsv_to_rgb_converter_unit.sv
tb/hsv_to_rgb_checker.sv
tb/tb_hsv_to_rgb_converter_unit.sv
